>>> rtl/v2n_pkg.sv
// package for the 2d vector normalise core
// widths and shared types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package v2n_pkg;
    localparam int COMP_W = 16;
    localparam int SQ_W   = 32;
    localparam int LEN_W  = 16;
    localparam int NUM_W  = 31;   // |component| * 16384 fits in 31 bits
    localparam int QUO_W  = 15;   // quotient magnitude up to 16384

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic [LEN_W-1:0] t_len;
endpackage
`default_nettype wire

>>> rtl/vector2_normalize_core.sv
// top level of the 2d vector normalise core
// squares stage, v2n_sqrt and v2n_div; depends on v2n_pkg
//
// channel  | direction | handshake          | payload
// request  | in        | start / busy       | i_vec_x, i_vec_y
// result   | out       | o_done strobe      | o_vec_length, o_dir_x, o_dir_y
//
// one request per cycle; busy is always low
// pipeline: squaring register, sum register, 16 square root stages, 15 divider stages
// synchronous active-low reset clears only the valid bits
// results cannot be stalled, each shows for one cycle
`timescale 1ns / 1ps
`default_nettype none
module vector2_normalize_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire v2n_pkg::t_comp        i_vec_x,
    input  wire v2n_pkg::t_comp        i_vec_y,
    output logic                       o_done,
    output v2n_pkg::t_len              o_vec_length,
    output v2n_pkg::t_comp             o_dir_x,
    output v2n_pkg::t_comp             o_dir_y
);
    import v2n_pkg::*;

    logic          r_v0, r_v1;
    t_comp         r_x0, r_y0, r_x1, r_y1;
    logic [31:0]   r_xx, r_yy, r_sq;
    logic          s_v;
    t_len          s_len;
    t_comp         s_x, s_y;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= start;
            r_v1 <= r_v0;
        end
        r_x0 <= i_vec_x;
        r_y0 <= i_vec_y;
        r_xx <= 32'($signed(i_vec_x) * $signed(i_vec_x));
        r_yy <= 32'($signed(i_vec_y) * $signed(i_vec_y));
        r_x1 <= r_x0;
        r_y1 <= r_y0;
        r_sq <= r_xx + r_yy;
    end

    v2n_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_sq    (r_sq),
        .i_x     (r_x1),
        .i_y     (r_y1),
        .o_valid (s_v),
        .o_len   (s_len),
        .o_x     (s_x),
        .o_y     (s_y)
    );

    v2n_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_v),
        .i_len   (s_len),
        .i_x     (s_x),
        .i_y     (s_y),
        .o_valid (o_done),
        .o_len   (o_vec_length),
        .o_dir_x (o_dir_x),
        .o_dir_y (o_dir_y)
    );
endmodule
`default_nettype wire

>>> rtl/v2n_sqrt.sv
// pipelined restoring square root, one result bit per stage
// depends on v2n_pkg
`timescale 1ns / 1ps
`default_nettype none
module v2n_sqrt (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [31:0]          i_sq,
    input  wire v2n_pkg::t_comp       i_x,
    input  wire v2n_pkg::t_comp       i_y,
    output logic                      o_valid,
    output v2n_pkg::t_len             o_len,
    output v2n_pkg::t_comp            o_x,
    output v2n_pkg::t_comp            o_y
);
    import v2n_pkg::*;
    localparam int N = LEN_W;

    logic          r_v   [N+1];
    logic [31:0]   r_rem [N+1];
    logic [N-1:0]  r_res [N+1];
    t_comp         r_x   [N+1];
    t_comp         r_y   [N+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_rem[0] = i_sq;
        r_res[0] = '0;
        r_x[0]   = i_x;
        r_y[0]   = i_y;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        localparam int B = N - 1 - s;
        logic [33:0] n_trial;
        logic [33:0] n_remw;
        always_comb begin
            n_trial = ({18'd0, r_res[s]} << (B + 1)) | (34'd1 << (2 * B));
            n_remw  = {2'b00, r_rem[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_x[s+1] <= r_x[s];
            r_y[s+1] <= r_y[s];
            if (n_remw >= n_trial) begin
                r_rem[s+1] <= 32'(n_remw - n_trial);
                r_res[s+1] <= r_res[s] | (N'(1) << B);
            end else begin
                r_rem[s+1] <= r_rem[s];
                r_res[s+1] <= r_res[s];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_len   = r_res[N];
    assign o_x     = r_x[N];
    assign o_y     = r_y[N];
endmodule
`default_nettype wire

>>> rtl/v2n_div.sv
// pipelined restoring divider for both direction components
// depends on v2n_pkg
`timescale 1ns / 1ps
`default_nettype none
module v2n_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire v2n_pkg::t_len      i_len,
    input  wire v2n_pkg::t_comp     i_x,
    input  wire v2n_pkg::t_comp     i_y,
    output logic                    o_valid,
    output v2n_pkg::t_len           o_len,
    output v2n_pkg::t_comp          o_dir_x,
    output v2n_pkg::t_comp          o_dir_y
);
    import v2n_pkg::*;
    localparam int Q = QUO_W;

    logic            r_v  [Q+1];
    t_len            r_len[Q+1];
    logic [NUM_W-1:0] r_nx [Q+1];
    logic [NUM_W-1:0] r_ny [Q+1];
    logic [Q-1:0]    r_qx [Q+1];
    logic [Q-1:0]    r_qy [Q+1];
    logic            r_sx [Q+1];
    logic            r_sy [Q+1];

    logic [COMP_W:0] n_ax, n_ay;
    always_comb begin
        n_ax = i_x[COMP_W-1] ? 17'(-{i_x[COMP_W-1], i_x}) : {1'b0, i_x};
        n_ay = i_y[COMP_W-1] ? 17'(-{i_y[COMP_W-1], i_y}) : {1'b0, i_y};
        r_v[0]   = i_valid;
        r_len[0] = i_len;
        r_nx[0]  = NUM_W'(n_ax) << 14;
        r_ny[0]  = NUM_W'(n_ay) << 14;
        r_qx[0]  = '0;
        r_qy[0]  = '0;
        r_sx[0]  = i_x[COMP_W-1];
        r_sy[0]  = i_y[COMP_W-1];
    end

    for (genvar s = 0; s < Q; s++) begin : g_st
        localparam int B = Q - 1 - s;
        logic [NUM_W+Q-1:0] n_d;
        always_comb n_d = (NUM_W+Q)'(r_len[s]) << B;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_len[s+1] <= r_len[s];
            r_sx[s+1]  <= r_sx[s];
            r_sy[s+1]  <= r_sy[s];
            if ((NUM_W+Q)'(r_nx[s]) >= n_d && r_len[s] != '0) begin
                r_nx[s+1] <= NUM_W'((NUM_W+Q)'(r_nx[s]) - n_d);
                r_qx[s+1] <= r_qx[s] | (Q'(1) << B);
            end else begin
                r_nx[s+1] <= r_nx[s];
                r_qx[s+1] <= r_qx[s];
            end
            if ((NUM_W+Q)'(r_ny[s]) >= n_d && r_len[s] != '0) begin
                r_ny[s+1] <= NUM_W'((NUM_W+Q)'(r_ny[s]) - n_d);
                r_qy[s+1] <= r_qy[s] | (Q'(1) << B);
            end else begin
                r_ny[s+1] <= r_ny[s];
                r_qy[s+1] <= r_qy[s];
            end
        end
    end

    assign o_valid = r_v[Q];
    assign o_len   = r_len[Q];
    assign o_dir_x = r_sx[Q] ? COMP_W'(-{1'b0, r_qx[Q]}) : COMP_W'({1'b0, r_qx[Q]});
    assign o_dir_y = r_sy[Q] ? COMP_W'(-{1'b0, r_qy[Q]}) : COMP_W'({1'b0, r_qy[Q]});
endmodule
`default_nettype wire

>>> rtl/v2n_checker.sv
// port-level checks for the 2d vector normalise core
// bound to vector2_normalize_core; depends on v2n_pkg
`timescale 1ns / 1ps
`default_nettype none
module v2n_props (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           busy,
    input wire logic           o_done,
    input wire v2n_pkg::t_len  o_vec_length,
    input wire v2n_pkg::t_comp o_dir_x,
    input wire v2n_pkg::t_comp o_dir_y
);
    import v2n_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_vec_length == '0 |-> o_dir_x == '0 && o_dir_y == '0)
        else $error("zero length with non-zero direction");
    a_dir_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $signed(o_dir_x) <= 16384 && $signed(o_dir_x) >= -16384)
        else $error("dir_x out of range");
    a_dir_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $signed(o_dir_y) <= 16384 && $signed(o_dir_y) >= -16384)
        else $error("dir_y out of range");
endmodule

bind vector2_normalize_core v2n_props u_v2n_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_done       (o_done),
    .o_vec_length (o_vec_length),
    .o_dir_x      (o_dir_x),
    .o_dir_y      (o_dir_y)
);
`default_nettype wire
